>>> sv/cbls_pkg.sv
// Shared constants, codes and the command type of the line smoother.
package cbls_pkg;

	localparam int WSEL_BITS      = 2;
	localparam int LINE_LEN_BITS  = 15;
	localparam int CFG_INDEX_BITS = 1;
	localparam int COL_BITS       = 14;
	localparam int OUT_BITS       = 16;
	localparam int HALF_BITS      = 3;
	localparam int MIN_LINE       = 9;
	localparam int LINE_LEN_RESET = 16384;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_SELECT = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_LENGTH   = 1'b1;

	// Divisor codes carried from the front to the back.
	localparam logic [1:0] DIV_3 = 2'd0;
	localparam logic [1:0] DIV_5 = 2'd1;
	localparam logic [1:0] DIV_9 = 2'd2;

	typedef struct packed {
		logic                 has_main;
		logic                 main_avg;
		logic                 last;
		logic [1:0]           div_sel;
		logic [HALF_BITS-1:0] half;
		logic [COL_BITS-1:0]  col;
	} cmd_t;

endpackage

>>> sv/cbls_front.sv
// Front end: configuration, delay line, column count and command build per word.
module cbls_front import cbls_pkg::*; #(
	parameter int MAX_TAPS    = 9,
	parameter int MAX_LINE    = 16384,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_write,
	input  logic [CFG_INDEX_BITS-1:0]                 cfg_index,
	input  logic [LINE_LEN_BITS-1:0]                  cfg_data,
	input  logic                                      accept,
	input  logic [OUT_BITS-1:0]                       sample,
	output cmd_t                                      cmd,
	output logic [SAMPLE_BITS-1:0]                    raw,
	output logic [SAMPLE_BITS+$clog2(MAX_TAPS)-1:0]   sum,
	output logic [MAX_TAPS/2-1:0][SAMPLE_BITS-1:0]    flush_taps
);

	localparam int HMAX = MAX_TAPS / 2;
	localparam int SW   = SAMPLE_BITS + $clog2(MAX_TAPS);
	localparam int CW   = $clog2(MAX_LINE);
	localparam int LW   = (CW + 1 > LINE_LEN_BITS) ? CW + 1 : LINE_LEN_BITS;

	localparam logic [WSEL_BITS-1:0] WIN_3 = 2'd0;
	localparam logic [WSEL_BITS-1:0] WIN_5 = 2'd1;

	logic [WSEL_BITS-1:0]                  window_select_q;
	logic [LINE_LEN_BITS-1:0]              line_length_q;
	logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0]  taps_q;
	logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0]  taps_new;
	logic [CW-1:0]                         input_column_q;
	logic [1:0]                            div_sel;
	logic [3:0]                            tap_count;
	logic [HALF_BITS-1:0]                  half;
	logic [LW-1:0]                         len_ext;
	logic [LW-1:0]                         eff_len;
	logic                                  last;
	logic [CW-1:0]                         main_col;

	// Requested window, stepped down until it fits the delay line.
	always_comb begin
		unique case (window_select_q)
			WIN_3:   div_sel = DIV_3;
			WIN_5:   div_sel = DIV_5;
			default: div_sel = DIV_9;
		endcase
		if (div_sel == DIV_9 && MAX_TAPS < 9)
			div_sel = DIV_5;
		if (div_sel == DIV_5 && MAX_TAPS < 5)
			div_sel = DIV_3;
	end

	always_comb begin
		unique case (div_sel)
			DIV_3: begin
				tap_count = 4'd3;
				half      = 3'd1;
			end
			DIV_5: begin
				tap_count = 4'd5;
				half      = 3'd2;
			end
			default: begin
				tap_count = 4'd9;
				half      = 3'd4;
			end
		endcase
	end

	always_comb begin
		len_ext = LW'(line_length_q);
		if (len_ext < LW'(MIN_LINE))
			eff_len = LW'(MIN_LINE);
		else if (len_ext > LW'(MAX_LINE))
			eff_len = LW'(MAX_LINE);
		else
			eff_len = len_ext;
	end

	assign last     = (LW'(input_column_q) + LW'(1)) >= eff_len;
	assign main_col = input_column_q - CW'(half);

	always_comb begin
		taps_new[0] = sample[SAMPLE_BITS-1:0];
		for (int i = 1; i < MAX_TAPS; i++)
			taps_new[i] = taps_q[i-1];
	end

	always_comb begin
		raw = '0;
		sum = '0;
		for (int i = 0; i < MAX_TAPS; i++) begin
			if (i == int'(half))
				raw = taps_new[i];
			if (i < int'(tap_count))
				sum = sum + SW'(taps_new[i]);
		end
		for (int i = 0; i < HMAX; i++)
			flush_taps[i] = taps_new[i];
	end

	always_comb begin
		cmd.has_main = input_column_q >= CW'(half);
		cmd.main_avg = main_col >= CW'(half);
		cmd.last     = last;
		cmd.div_sel  = div_sel;
		cmd.half     = half;
		cmd.col      = COL_BITS'(input_column_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_select_q <= '0;
			line_length_q   <= LINE_LEN_BITS'(LINE_LEN_RESET);
			taps_q          <= '0;
			input_column_q  <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_WINDOW_SELECT: window_select_q <= cfg_data[WSEL_BITS-1:0];
					REG_LINE_LENGTH:   line_length_q   <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				taps_q         <= taps_new;
				input_column_q <= last ? '0 : input_column_q + CW'(1);
			end
		end
	end

endmodule

>>> sv/cbls_queue.sv
// Short command queue between the front end and the back end.
module cbls_queue #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	output logic          full,
	input  logic          pop,
	output logic [DW-1:0] pop_data,
	output logic          empty
);

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);
	localparam int NW    = $clog2(DEPTH + 1);

	logic [DEPTH-1:0][DW-1:0] mem_q;
	logic [PW-1:0]            wr_ptr_q;
	logic [PW-1:0]            rd_ptr_q;
	logic [NW-1:0]            count_q;

	assign full     = count_q == NW'(DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			count_q <= count_q + NW'(push) - NW'(pop);
		end
	end

endmodule

>>> sv/cbls_back.sv
// Back end: divide by the tap count and sequence each command's results to the output.
module cbls_back import cbls_pkg::*; #(
	parameter int MAX_TAPS    = 9,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      empty,
	output logic                                      pop,
	input  cmd_t                                      cmd,
	input  logic [SAMPLE_BITS-1:0]                    raw,
	input  logic [SAMPLE_BITS+$clog2(MAX_TAPS)-1:0]   sum,
	input  logic [MAX_TAPS/2-1:0][SAMPLE_BITS-1:0]    flush_taps,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic [OUT_BITS-1:0]                       smoothed,
	output logic [COL_BITS-1:0]                       column,
	output logic                                      line_done
);

	localparam int HMAX = MAX_TAPS / 2;
	localparam int SW   = SAMPLE_BITS + $clog2(MAX_TAPS);
	// Reciprocal scale; exact floor for every window sum below 2**(SAMPLE_BITS+4).
	localparam int K    = SAMPLE_BITS + 8;
	localparam int MW   = K - 1;
	localparam logic [MW-1:0] RECIP_3 = MW'(((1 << K) + 2) / 3);
	localparam logic [MW-1:0] RECIP_5 = MW'(((1 << K) + 4) / 5);
	localparam logic [MW-1:0] RECIP_9 = MW'(((1 << K) + 8) / 9);

	logic [MW-1:0]                      recip;
	logic [SW+MW-1:0]                   prod;
	cmd_t                               cmd_s1;
	logic [SAMPLE_BITS-1:0]             raw_s1;
	logic [SW+MW-1:0]                   prod_s1;
	logic [HMAX-1:0][SAMPLE_BITS-1:0]   taps_s1;
	logic                               main_pend_s1;
	logic [HALF_BITS-1:0]               flush_k_s1;
	logic [HALF_BITS-1:0]               k_sel;
	logic                               pending;
	logic                               emit_ok;
	logic                               emit;
	logic                               last_one;
	logic                               s1_free;
	logic [SAMPLE_BITS-1:0]             flush_val;
	logic [SAMPLE_BITS-1:0]             res_val;
	logic [COL_BITS-1:0]                res_col;
	logic                               res_done;
	logic                               out_valid_q;
	logic [OUT_BITS-1:0]                smoothed_q;
	logic [COL_BITS-1:0]                column_q;
	logic                               line_done_q;

	always_comb begin
		unique case (cmd.div_sel)
			DIV_3:   recip = RECIP_3;
			DIV_5:   recip = RECIP_5;
			default: recip = RECIP_9;
		endcase
	end

	assign prod = sum * recip;

	// A command yields its centered result first, then the flush run from the
	// oldest held column down to the newest.
	assign pending  = main_pend_s1 || (flush_k_s1 != '0);
	assign emit_ok  = !out_valid_q || !out_stall;
	assign emit     = pending && emit_ok;
	assign last_one = main_pend_s1 ? (flush_k_s1 == '0) : (flush_k_s1 == HALF_BITS'(1));
	assign s1_free  = !pending || (emit && last_one);
	assign pop      = !empty && s1_free;
	assign k_sel    = flush_k_s1 - HALF_BITS'(1);

	always_comb begin
		flush_val = '0;
		for (int i = 0; i < HMAX; i++) begin
			if (i == int'(k_sel))
				flush_val = taps_s1[i];
		end
	end

	always_comb begin
		if (main_pend_s1) begin
			res_val  = cmd_s1.main_avg ? prod_s1[K +: SAMPLE_BITS] : raw_s1;
			res_col  = cmd_s1.col - COL_BITS'(cmd_s1.half);
			res_done = 1'b0;
		end else begin
			res_val  = flush_val;
			res_col  = cmd_s1.col - COL_BITS'(k_sel);
			res_done = k_sel == '0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1  <= cmd;
			raw_s1  <= raw;
			prod_s1 <= prod;
			taps_s1 <= flush_taps;
		end
		if (emit) begin
			smoothed_q  <= OUT_BITS'(res_val);
			column_q    <= res_col;
			line_done_q <= res_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_pend_s1 <= 1'b0;
			flush_k_s1   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				main_pend_s1 <= cmd.has_main;
				flush_k_s1   <= cmd.last ? cmd.half : '0;
			end else if (emit) begin
				if (main_pend_s1)
					main_pend_s1 <= 1'b0;
				else
					flush_k_s1 <= k_sel;
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign smoothed  = smoothed_q;
	assign column    = column_q;
	assign line_done = line_done_q;

endmodule

>>> sv/centered_boxcar_line_smoother.sv
// Top level of the centered boxcar line smoother.
// The block takes one sample word per clock while the command queue is not full and
// gives one result word per clock while the output is not stalled. Results lag the
// input by half a window: the first half-window words of a line produce nothing, and
// every later word produces the result for the column half a window back (the raw
// value within half a window of the line start). The line's last word also produces
// the remaining half-window results, so that word yields 2, 3 or 5 results for 3, 5
// or 9 taps from the output sequencer. A four-entry command queue sits between the
// delay line and the sequencer, so input keeps flowing during that run until the
// queue fills. The window sum is divided by a reciprocal multiply registered before
// the output. Configuration must be written only while no word is in flight; the
// block itself does not enforce this. A new window applies from the next word.
module centered_boxcar_line_smoother import cbls_pkg::*; #(
	parameter int MAX_TAPS    = 9,
	parameter int MAX_LINE    = 16384,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [LINE_LEN_BITS-1:0]  cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [OUT_BITS-1:0]       sample,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [OUT_BITS-1:0]       smoothed,
	output logic [COL_BITS-1:0]       column,
	output logic                      line_done
);

	localparam int HMAX = MAX_TAPS / 2;
	localparam int SW   = SAMPLE_BITS + $clog2(MAX_TAPS);
	localparam int DW   = $bits(cmd_t) + SAMPLE_BITS + SW + HMAX * SAMPLE_BITS;

	logic                               accept;
	cmd_t                               f_cmd;
	logic [SAMPLE_BITS-1:0]             f_raw;
	logic [SW-1:0]                      f_sum;
	logic [HMAX-1:0][SAMPLE_BITS-1:0]   f_taps;
	logic                               q_full;
	logic                               q_empty;
	logic                               q_pop;
	logic [DW-1:0]                      q_out;
	cmd_t                               q_cmd;
	logic [SAMPLE_BITS-1:0]             q_raw;
	logic [SW-1:0]                      q_sum;
	logic [HMAX-1:0][SAMPLE_BITS-1:0]   q_taps;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	cbls_front #(
		.MAX_TAPS    (MAX_TAPS),
		.MAX_LINE    (MAX_LINE),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.sample     (sample),
		.cmd        (f_cmd),
		.raw        (f_raw),
		.sum        (f_sum),
		.flush_taps (f_taps)
	);

	cbls_queue #(
		.DW (DW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data ({f_cmd, f_raw, f_sum, f_taps}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	assign {q_cmd, q_raw, q_sum, q_taps} = q_out;

	cbls_back #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (q_empty),
		.pop        (q_pop),
		.cmd        (q_cmd),
		.raw        (q_raw),
		.sum        (q_sum),
		.flush_taps (q_taps),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.smoothed   (smoothed),
		.column     (column),
		.line_done  (line_done)
	);

endmodule
